// File: rtl/cpu_addressing_mode_unit_assert.svh
// Assertion macros for the 6502 addressing mode unit.
// Depends on nothing; included by the modules that check their own logic.
`ifndef CPU_ADDRESSING_MODE_UNIT_ASSERT_SVH
`define CPU_ADDRESSING_MODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on the rising clock edge, skipped while reset is asserted.
`define CAM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("cam assertion failed");
// Checked on every rising clock edge, during reset too.
`define CAM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("cam assertion failed");
`else
`define CAM_ASSERT(lbl, clk, rst_n, prop)
`define CAM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/cam_pkg.sv
// Shared codes and types for the 6502 addressing mode unit.
// No dependencies.
package cam_pkg;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// addressing modes
	localparam logic [3:0] MODE_IMM  = 4'd0;
	localparam logic [3:0] MODE_ZP   = 4'd1;
	localparam logic [3:0] MODE_ZPX  = 4'd2;
	localparam logic [3:0] MODE_ZPY  = 4'd3;
	localparam logic [3:0] MODE_ABS  = 4'd4;
	localparam logic [3:0] MODE_ABSX = 4'd5;
	localparam logic [3:0] MODE_ABSY = 4'd6;
	localparam logic [3:0] MODE_IND  = 4'd7;
	localparam logic [3:0] MODE_INDX = 4'd8;
	localparam logic [3:0] MODE_INDY = 4'd9;

	// result kinds
	localparam logic KIND_READ_REQ = 1'b0;
	localparam logic KIND_ADDR     = 1'b1;

	// pointer fetch phases
	localparam logic [1:0] PH_IDLE      = 2'd0;
	localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
	localparam logic [1:0] PH_WAIT_HIGH = 2'd2;

	typedef struct packed {
		logic        kind;
		logic [15:0] address;
		logic [15:0] next_pc;
		logic        extra_cycle;
		logic        protocol_error;
	} res_t;

endpackage

// File: rtl/cpu_addressing_mode_unit.sv
// 6502 effective-address unit: ten addressing modes, pointer fetch sequencing.
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle; in_ready is high while the output register
// is empty or being drained, so a held result stalls the input in that cycle.
// Reset (arst_n low, asynchronous): pointer phase idle, no result pending.
// Depends on cam_pkg and cpu_addressing_mode_unit_assert.svh.
`include "cpu_addressing_mode_unit_assert.svh"

module cpu_addressing_mode_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [3:0]  mode,
	input  logic [7:0]  operand_low,
	input  logic [7:0]  operand_high,
	input  logic [7:0]  index_x,
	input  logic [7:0]  index_y,
	input  logic [15:0] pc,
	input  logic        always_penalty,
	input  logic [7:0]  read_data,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [15:0] address,
	output logic [15:0] next_pc,
	output logic        extra_cycle,
	output logic        protocol_error
);

	// Pointer fetch state. Only phase_q needs a reset; the saved fields are
	// always written on the start item before any read data can use them.
	logic [1:0]  phase_q;
	logic [3:0]  pend_mode_q;
	logic [15:0] ptr_addr_q;
	logic [7:0]  low_byte_q;
	logic [7:0]  saved_y_q;
	logic        saved_pen_q;
	logic [15:0] saved_npc_q;

	// Result register
	logic         res_valid_q;
	cam_pkg::res_t res_q;

	logic          in_acc;
	cam_pkg::res_t res_d;
	logic [1:0]    phase_d;
	logic          start_ptr;   // start item that opens a pointer fetch
	logic [15:0]   start_ptr_addr;
	logic [15:0]   start_npc;
	logic          take_low;

	// Operand-derived values
	logic [15:0] pc1, pc2, abs_addr;
	logic [7:0]  zp_x, zp_y;
	logic [15:0] absx_sum, absy_sum;
	logic        absx_extra, absy_extra;
	// Completion of (zp),Y and plain pointer modes
	logic [15:0] ptr_base, indy_sum;
	logic        indy_extra;
	logic [15:0] ptr_next;

	assign in_ready = !res_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	assign pc1      = pc + 16'd1;
	assign pc2      = pc + 16'd2;
	assign abs_addr = {operand_high, operand_low};
	assign zp_x     = operand_low + index_x;   // wraps inside page zero
	assign zp_y     = operand_low + index_y;

	// Indexed absolute: page cross when the high byte changes
	assign absx_sum   = abs_addr + {8'h00, index_x};
	assign absy_sum   = abs_addr + {8'h00, index_y};
	assign absx_extra = (absx_sum[15:8] != abs_addr[15:8]) || always_penalty;
	assign absy_extra = (absy_sum[15:8] != abs_addr[15:8]) || always_penalty;

	assign ptr_base   = {read_data, low_byte_q};
	assign indy_sum   = ptr_base + {8'h00, saved_y_q};
	assign indy_extra = (indy_sum[15:8] != ptr_base[15:8]) || saved_pen_q;

	// High pointer byte stays within the pointer's page
	assign ptr_next = {ptr_addr_q[15:8], ptr_addr_q[7:0] + 8'd1};

	always_comb begin
		res_d          = '{kind: cam_pkg::KIND_ADDR, address: 16'h0000,
		                   next_pc: 16'h0000, extra_cycle: 1'b0,
		                   protocol_error: 1'b0};
		phase_d        = phase_q;
		start_ptr      = 1'b0;
		start_ptr_addr = abs_addr;
		start_npc      = pc1;
		take_low       = 1'b0;
		priority if (operation == cam_pkg::OP_START && phase_q != cam_pkg::PH_IDLE) begin
			// start while a pointer fetch is open: reject, keep state
			res_d.protocol_error = 1'b1;
		end else if (operation == cam_pkg::OP_START) begin
			unique case (mode)
				cam_pkg::MODE_IMM: begin
					res_d.address = pc;
					res_d.next_pc = pc1;
				end
				cam_pkg::MODE_ZP: begin
					res_d.address = {8'h00, operand_low};
					res_d.next_pc = pc1;
				end
				cam_pkg::MODE_ZPX: begin
					res_d.address     = {8'h00, zp_x};
					res_d.next_pc     = pc1;
					res_d.extra_cycle = 1'b1;
				end
				cam_pkg::MODE_ZPY: begin
					res_d.address     = {8'h00, zp_y};
					res_d.next_pc     = pc1;
					res_d.extra_cycle = 1'b1;
				end
				cam_pkg::MODE_ABS: begin
					res_d.address = abs_addr;
					res_d.next_pc = pc2;
				end
				cam_pkg::MODE_ABSX: begin
					res_d.address     = absx_sum;
					res_d.next_pc     = pc2;
					res_d.extra_cycle = absx_extra;
				end
				cam_pkg::MODE_ABSY: begin
					res_d.address     = absy_sum;
					res_d.next_pc     = pc2;
					res_d.extra_cycle = absy_extra;
				end
				cam_pkg::MODE_IND: begin
					start_ptr      = 1'b1;
					start_ptr_addr = abs_addr;
					start_npc      = pc2;
				end
				cam_pkg::MODE_INDX: begin
					start_ptr      = 1'b1;
					start_ptr_addr = {8'h00, zp_x};
					start_npc      = pc1;
				end
				cam_pkg::MODE_INDY: begin
					start_ptr      = 1'b1;
					start_ptr_addr = {8'h00, operand_low};
					start_npc      = pc1;
				end
				default: begin
					// unknown mode: nothing started
					res_d.next_pc        = pc;
					res_d.protocol_error = 1'b1;
				end
			endcase
			if (start_ptr) begin
				// request the pointer low byte
				res_d.kind    = cam_pkg::KIND_READ_REQ;
				res_d.address = start_ptr_addr;
				res_d.next_pc = start_npc;
				phase_d       = cam_pkg::PH_WAIT_LOW;
			end
		end else if (phase_q == cam_pkg::PH_WAIT_LOW) begin
			// low byte back: request the high byte
			take_low      = 1'b1;
			res_d.kind    = cam_pkg::KIND_READ_REQ;
			res_d.address = ptr_next;
			res_d.next_pc = saved_npc_q;
			phase_d       = cam_pkg::PH_WAIT_HIGH;
		end else if (phase_q == cam_pkg::PH_WAIT_HIGH) begin
			res_d.next_pc = saved_npc_q;
			phase_d       = cam_pkg::PH_IDLE;
			if (pend_mode_q == cam_pkg::MODE_INDY) begin
				res_d.address     = indy_sum;
				res_d.extra_cycle = indy_extra;
			end else begin
				res_d.address     = ptr_base;
				res_d.extra_cycle = (pend_mode_q == cam_pkg::MODE_INDX);
			end
		end else begin
			// read data with no fetch open
			res_d.protocol_error = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= cam_pkg::PH_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				phase_q     <= phase_d;
				res_valid_q <= 1'b1;
			end else if (out_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res_d;
			if (start_ptr) begin
				pend_mode_q <= mode;
				ptr_addr_q  <= start_ptr_addr;
				saved_y_q   <= index_y;
				saved_pen_q <= always_penalty;
				saved_npc_q <= start_npc;
			end
			if (take_low) begin
				low_byte_q <= read_data;
				ptr_addr_q <= ptr_next;
			end
		end
	end

	assign out_valid      = res_valid_q;
	assign kind           = res_q.kind;
	assign address        = res_q.address;
	assign next_pc        = res_q.next_pc;
	assign extra_cycle    = res_q.extra_cycle;
	assign protocol_error = res_q.protocol_error;

	// An accepted indirect start from idle opens the low-byte wait
	`CAM_ASSERT(a_ptr_open, clk, arst_n, (in_acc && operation == cam_pkg::OP_START && phase_q == cam_pkg::PH_IDLE && (mode == cam_pkg::MODE_IND || mode == cam_pkg::MODE_INDX || mode == cam_pkg::MODE_INDY)) |=> (phase_q == cam_pkg::PH_WAIT_LOW && kind == cam_pkg::KIND_READ_REQ))
	// The high byte closes the fetch with an address result
	`CAM_ASSERT(a_ptr_close, clk, arst_n, (in_acc && operation == cam_pkg::OP_READ && phase_q == cam_pkg::PH_WAIT_HIGH) |=> (phase_q == cam_pkg::PH_IDLE && kind == cam_pkg::KIND_ADDR && !protocol_error))
	// Read requests never carry an error or an extra cycle
	`CAM_ASSERT(a_req_clean, clk, arst_n, (out_valid && kind == cam_pkg::KIND_READ_REQ) |-> (!extra_cycle && !protocol_error))
	// The pointer phase only ever holds one of its three codes
	`CAM_ASSERT(a_phase_legal, clk, arst_n, (phase_q == cam_pkg::PH_IDLE || phase_q == cam_pkg::PH_WAIT_LOW || phase_q == cam_pkg::PH_WAIT_HIGH))
	// The pointer phase stays idle and no result is pending through reset
	`CAM_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> (phase_q == cam_pkg::PH_IDLE && !out_valid))

endmodule
